// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define APT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, quiet while reset is high.
`define APT_ASSERT_NEXT(label, clk, ante, cons, rst) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define APT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/apt_pkg.sv =====
// Package: types and constants of the affine point transform.
package apt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int NUM_REGS      = 6;
   localparam int NUM_LANES     = 3;
   // 3 full products plus shifted translation fit in 66 signed bits
   localparam int ACC_W         = 66;

   typedef enum logic [2:0] {
      REG_ROW0_XY = 3'd0,
      REG_ROW0_ZW = 3'd1,
      REG_ROW1_XY = 3'd2,
      REG_ROW1_ZW = 3'd3,
      REG_ROW2_XY = 3'd4,
      REG_ROW2_ZW = 3'd5
   } apt_reg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } apt_stage_en_type;

   localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

endpackage

// ===== hdl/apt_if.sv =====
// Interfaces: point request channel and transformed point response channel.
interface apt_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   pos_x;
   logic signed [31:0]   pos_y;
   logic signed [31:0]   pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface apt_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   out_x;
   logic signed [31:0]   out_y;
   logic signed [31:0]   out_z;
   logic                 overflow;

   modport source (output valid, out_x, out_y, out_z, overflow, input ready);
   modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

// ===== hdl/apt_csr.sv =====
// Register file: six 64-bit matrix row registers behind an APB-style port.
module apt_csr #(
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            psel,
   input  logic                                            penable,
   input  logic                                            pwrite,
   input  logic [apt_pkg::CSR_ADDR_W-1:0]                  paddr,
   input  logic [apt_pkg::CSR_DATA_W-1:0]                  pwdata,
   output logic [apt_pkg::CSR_DATA_W-1:0]                  prdata,
   output logic                                            pready,
   output logic [apt_pkg::NUM_REGS-1:0][apt_pkg::CSR_DATA_W-1:0] regs
);
   import apt_pkg::*;

   localparam logic [CSR_DATA_W-1:0] ONE = CSR_DATA_W'(1) << FRAC_BITS;

   logic [NUM_REGS-1:0][CSR_DATA_W-1:0] regs_ff;
   logic [NUM_REGS-1:0][CSR_DATA_W-1:0] regs_in;
   logic [NUM_REGS-1:0][CSR_DATA_W-1:0] regs_rst;
   logic [2:0]                          idx;
   logic                                wr;

   assign idx    = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // identity matrix
   always_comb begin
      regs_rst              = '0;
      regs_rst[REG_ROW0_XY] = ONE;
      regs_rst[REG_ROW1_XY] = ONE << 32;
      regs_rst[REG_ROW2_ZW] = ONE;
   end

   always_comb begin
      regs_in = regs_ff;
      if (wr && (idx < 3'(NUM_REGS))) begin
         regs_in[idx] = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= regs_rst;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (idx < 3'(NUM_REGS)) begin
         prdata = regs_ff[idx];
      end
   end

   assign regs = regs_ff;

endmodule

// ===== hdl/apt_lane.sv =====
// One row lane: three products, translation, rounding and shift back.
module apt_lane #(
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  apt_pkg::apt_stage_en_type             en,
   input  logic [apt_pkg::CSR_DATA_W-1:0]        coef_xy,
   input  logic [apt_pkg::CSR_DATA_W-1:0]        coef_zw,
   input  logic signed [apt_pkg::WORD_W-1:0]     pos_x,
   input  logic signed [apt_pkg::WORD_W-1:0]     pos_y,
   input  logic signed [apt_pkg::WORD_W-1:0]     pos_z,
   output logic signed [apt_pkg::ACC_W-1:0]      result
);
   import apt_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND = (ACC_W'(1) << FRAC_BITS) >> 1;

   logic signed [WORD_W-1:0]   m_x;
   logic signed [WORD_W-1:0]   m_y;
   logic signed [WORD_W-1:0]   m_z;
   logic signed [WORD_W-1:0]   m_w;

   logic signed [63:0]         prod_x_ff;
   logic signed [63:0]         prod_y_ff;
   logic signed [63:0]         prod_z_ff;
   logic signed [ACC_W-1:0]    trans_ff;
   logic signed [ACC_W-1:0]    sum_a_ff;
   logic signed [ACC_W-1:0]    sum_b_ff;
   logic signed [ACC_W-1:0]    res_ff;
   logic signed [ACC_W-1:0]    total;

   assign m_x = coef_xy[31:0];
   assign m_y = coef_xy[63:32];
   assign m_z = coef_zw[31:0];
   assign m_w = coef_zw[63:32];

   // stage 1: full-width products, translation moved up to the product scale
   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_x_ff <= 64'(m_x) * 64'(pos_x);
         prod_y_ff <= 64'(m_y) * 64'(pos_y);
         prod_z_ff <= 64'(m_z) * 64'(pos_z);
         trans_ff  <= ACC_W'(m_w) <<< FRAC_BITS;
      end
   end

   // stage 2: two partial sums, rounding term folded in
   always_ff @(posedge clock) begin
      if (en.s2) begin
         sum_a_ff <= ACC_W'(prod_x_ff) + ACC_W'(prod_y_ff);
         sum_b_ff <= ACC_W'(prod_z_ff) + trans_ff + ROUND;
      end
   end

   // stage 3: final sum, arithmetic shift back to Q format
   assign total = sum_a_ff + sum_b_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         res_ff <= total >>> FRAC_BITS;
      end
   end

   assign result = res_ff;

endmodule

// ===== hdl/apt_merge.sv =====
// Merge stage: saturates the three lane results, ORs overflow, holds the beat.
module apt_merge (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                in_valid,
   output logic                                                in_ready,
   input  logic [apt_pkg::NUM_LANES-1:0][apt_pkg::ACC_W-1:0]   lane_res,
   apt_rsp_if.source                                           rsp
);
   import apt_pkg::*;

   logic                                  valid_ff;
   logic                                  valid_in;
   logic [NUM_LANES-1:0][WORD_W-1:0]      sat;
   logic [NUM_LANES-1:0]                  ovf;
   logic [NUM_LANES-1:0][WORD_W-1:0]      data_ff;
   logic                                  ovf_ff;
   logic                                  load;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         // fits when bits above the 32-bit sign are all copies of it
         if ((&lane_res[i][ACC_W-1:WORD_W-1]) || !(|lane_res[i][ACC_W-1:WORD_W-1])) begin
            sat[i] = lane_res[i][WORD_W-1:0];
            ovf[i] = 1'b0;
         end else begin
            sat[i] = lane_res[i][ACC_W-1] ? SAT_MIN : SAT_MAX;
            ovf[i] = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || rsp.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= sat;
         ovf_ff  <= |ovf;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_x    = data_ff[0];
   assign rsp.out_y    = data_ff[1];
   assign rsp.out_z    = data_ff[2];
   assign rsp.overflow = ovf_ff;

endmodule

// ===== hdl/affine_point_transform.sv =====
// Top level: 3x4 affine transform of a stream of Q-format 3D points.
//
//  channel   dir  handshake        beat contents
//  req_bus   in   valid/ready      pos_x, pos_y, pos_z (signed Q16.16)
//  rsp_bus   out  valid/ready      out_x, out_y, out_z (saturated), overflow
//  csr       in   APB psel/penable row0..row2 xy/zw, 64-bit, at 8*index
//
// One beat in and one beat out per cycle when the sink keeps up.
// A beat passes the product, partial-sum and final-sum-and-shift registers,
// then is saturated into the output register. The three 32x32 multipliers per
// lane set the first stage.
// Synchronous reset empties the pipeline and loads the identity matrix.
// A stall on rsp_bus at once halts each full stage with no empty stage after
// it, and the rest keep moving; req_bus.ready drops only once every stage holds a beat.
module affine_point_transform #(
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   apt_req_if.sink                          req_bus,
   apt_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [apt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [apt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [apt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import apt_pkg::*;

   logic [NUM_REGS-1:0][CSR_DATA_W-1:0]   regs;
   logic [NUM_LANES-1:0][ACC_W-1:0]       lane_res;
   apt_stage_en_type                      en;
   logic                                  merge_ready;

   // stage valid bits, one per lane pipeline stage (lanes run in lockstep)
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   apt_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   // a stage advances when it is empty or the stage after it advances
   assign en.s3 = !v3_ff || merge_ready;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_bus.ready = en.s1;

   assign v1_in = en.s1 ? req_bus.valid : v1_ff;
   assign v2_in = en.s2 ? v1_ff : v2_ff;
   assign v3_in = en.s3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // one lane per matrix row; row r uses registers 2r and 2r+1
   for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
      apt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (en),
         .coef_xy (regs[2*r]),
         .coef_zw (regs[2*r+1]),
         .pos_x   (req_bus.pos_x),
         .pos_y   (req_bus.pos_y),
         .pos_z   (req_bus.pos_z),
         .result  (lane_res[r])
      );
   end

   apt_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_ready (merge_ready),
      .lane_res (lane_res),
      .rsp      (rsp_bus)
   );

endmodule

// ===== hdl/apt_checker.sv =====
// Port-level checker for the affine point transform, bound to the top level.
`include "assert_macros.svh"

module apt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [apt_pkg::WORD_W-1:0] out_x,
   input logic signed [apt_pkg::WORD_W-1:0] out_y,
   input logic signed [apt_pkg::WORD_W-1:0] out_z,
   input logic                              overflow
);
   import apt_pkg::*;

   logic x_sat, y_sat, z_sat;

   assign x_sat = (out_x == SAT_MAX) || (out_x == SAT_MIN);
   assign y_sat = (out_y == SAT_MAX) || (out_y == SAT_MIN);
   assign z_sat = (out_z == SAT_MAX) || (out_z == SAT_MIN);

   // a held beat keeps its contents while stalled
   `APT_ASSERT_NEXT(a_rsp_hold, clock, rsp_valid && !rsp_ready, rsp_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(overflow), reset)

   // overflow only comes with a clamped component
   `APT_ASSERT_IMP(a_ovf_sat, clock, reset, rsp_valid && overflow, x_sat || y_sat || z_sat)

   // a sink that takes every beat never stalls the source side
   `APT_ASSERT_IMP(a_no_stall, clock, reset, rsp_ready, req_ready)

   // reset leaves no beat on the response side
   `APT_ASSERT_NEXT_ALWAYS(a_rst_empty, clock, reset, !rsp_valid)

endmodule

bind affine_point_transform apt_checker u_apt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_x     (rsp_bus.out_x),
   .out_y     (rsp_bus.out_y),
   .out_z     (rsp_bus.out_z),
   .overflow  (rsp_bus.overflow)
);
